@@ hw/rtl/icmpf_pkg.sv @@
// icmpf_pkg: shared types and constants for the icmp echo packet filter
// no dependencies; imported by the parser, the verdict queue and the top level

package icmpf_pkg;

    // word accepted on the input channel, one packet byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // word delivered on the output channel, one verdict per packet
    typedef struct packed {
        logic       drop;
        logic [2:0] reason;
        logic [2:0] vlan_tags;
    } t_out_word;

    // verdict reason codes
    localparam logic [2:0] RSN_EVEN_ECHO = 3'd0;
    localparam logic [2:0] RSN_L2        = 3'd1;
    localparam logic [2:0] RSN_IP4       = 3'd2;
    localparam logic [2:0] RSN_IP6       = 3'd3;
    localparam logic [2:0] RSN_ICMP      = 3'd4;
    localparam logic [2:0] RSN_ODD_SEQ   = 3'd5;

    // ethertypes
    localparam logic [15:0] ET_IP4   = 16'h0800;
    localparam logic [15:0] ET_IP6   = 16'h86DD;
    localparam logic [15:0] ET_VLANQ = 16'h8100;
    localparam logic [15:0] ET_VLANA = 16'h88A8;

    // header fields and offsets
    localparam logic [7:0] ETH_TYPE_HI   = 8'd12;
    localparam logic [7:0] ETH_TYPE_LO   = 8'd13;
    localparam logic [7:0] VLAN_TYPE_HI  = 8'd2;
    localparam logic [7:0] VLAN_TYPE_LO  = 8'd3;
    localparam logic [7:0] IP4_VER_IHL   = 8'd0;
    localparam logic [7:0] IP4_PROTO     = 8'd9;
    localparam logic [7:0] IP4_MIN_LAST  = 8'd19;
    localparam logic [5:0] IP4_MIN_HLEN  = 6'd20;
    localparam logic [7:0] IP6_NEXT_HDR  = 8'd6;
    localparam logic [7:0] IP6_LAST      = 8'd39;
    localparam logic [7:0] ICMP_TYPE     = 8'd0;
    localparam logic [7:0] ICMP_SEQ_LO   = 8'd7;
    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam logic [7:0] NH_ICMP6      = 8'd58;
    localparam logic [7:0] ECHO_REQ4     = 8'd8;
    localparam logic [7:0] ECHO_REQ6     = 8'd128;
    localparam logic [7:0] OFFSET_MAX    = 8'd255;

    // verdict queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // parser phases
    typedef enum logic [5:0] {
        PH_ETH  = 6'b000001,
        PH_VLAN = 6'b000010,
        PH_IP4  = 6'b000100,
        PH_IP6  = 6'b001000,
        PH_ICMP = 6'b010000,
        PH_DONE = 6'b100000
    } t_phase;

endpackage

@@ hw/rtl/icmp_echo_packet_filter.sv @@
// icmp_echo_packet_filter: top level, byte parser feeding a verdict queue
// depends on icmpf_pkg, icmpf_parser, icmpf_queue
//
// usage
//   input channel (i_valid / o_ready / i_data): one packet byte per word, in
//   wire order, with last_byte set on the final byte of each packet
//   output channel (o_valid / i_ready / o_data): one verdict word per packet,
//   giving drop, reason and the number of complete vlan tags
// timing
//   one byte is taken every cycle while the queue is not full; the header walk
//   updates a few registers per byte, so the parser keeps that rate; a verdict
//   is queued with its last byte and reaches o_data after those ahead of it
// stall
//   verdicts wait in a 4-entry queue; o_ready drops only while that queue is
//   full, so the input keeps moving during short output stalls
// reset
//   i_rst_n low (synchronous) empties the queue and puts the parser back at
//   the start of the ethernet header; no verdict is pending after reset

module icmp_echo_packet_filter #(
    parameter int MAX_VLAN_TAGS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  icmpf_pkg::t_in_word  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output icmpf_pkg::t_out_word o_data
);
    import icmpf_pkg::*;

    logic      full;
    logic      push;
    t_out_word verdict;

    // front end: header parser
    icmpf_parser #(
        .MAX_VLAN_TAGS(MAX_VLAN_TAGS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .o_ready   (o_ready),
        .i_full    (full),
        .o_push    (push),
        .o_verdict (verdict)
    );

    // back end: verdict queue on the output channel
    icmpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (verdict),
        .o_full  (full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_data)
    );

    // a packet end always leaves a verdict waiting next cycle
    a_verdict_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.last_byte) |=> o_valid)
        else $error("no verdict after last byte");

    // only an even echo request is dropped
    a_drop_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.drop == (o_data.reason == RSN_EVEN_ECHO)))
        else $error("drop flag and reason disagree");

    // reason code stays within the defined set
    a_reason_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.reason <= RSN_ODD_SEQ))
        else $error("undefined reason code");

    // a full queue that is not read keeps o_ready low, so no byte is taken
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && $past(o_valid && !i_ready && !o_ready)) |-> !o_ready)
        else $error("input taken while verdict queue full");

endmodule

@@ hw/rtl/icmpf_parser.sv @@
// icmpf_parser: front end, walks the headers one byte per cycle while the queue has room and forms a verdict
// depends on icmpf_pkg

module icmpf_parser #(
    parameter int MAX_VLAN_TAGS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  icmpf_pkg::t_in_word i_data,
    output logic                o_ready,
    input  logic                i_full,
    output logic                o_push,
    output icmpf_pkg::t_out_word o_verdict
);
    import icmpf_pkg::*;

    localparam int TAG_W = (MAX_VLAN_TAGS < 1) ? 1 : $clog2(MAX_VLAN_TAGS + 1);
    localparam logic [TAG_W:0] MAX_TAGS = (TAG_W + 1)'(MAX_VLAN_TAGS);

    logic [7:0]       r_offset,  n_offset;
    t_phase           r_phase,   n_phase;
    logic [15:0]      r_etype,   n_etype;
    logic [TAG_W-1:0] r_tags,    n_tags;
    logic [5:0]       r_l3_len,  n_l3_len;
    logic [7:0]       r_start,   n_start;
    logic [3:0]       r_pending, n_pending;

    logic [7:0]       rel;
    logic [7:0]       b;
    logic             accept;
    logic [TAG_W+2:0] tags_ext;

    // next phase once an ethernet header or a vlan tag is complete
    function automatic t_phase f_dispatch(input logic [15:0] et, input logic [TAG_W-1:0] tags);
        logic is_vlan;
        is_vlan = (et == ET_VLANQ) || (et == ET_VLANA);
        if (is_vlan && ({1'b0, tags} < MAX_TAGS)) begin
            return PH_VLAN;
        end else if (is_vlan) begin
            return PH_DONE;
        end else if (et == ET_IP4) begin
            return PH_IP4;
        end else if (et == ET_IP6) begin
            return PH_IP6;
        end
        return PH_DONE;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign b       = i_data.data_byte;
    assign rel     = r_offset - r_start;

    // per-byte header walk
    always_comb begin
        n_offset  = (r_offset == OFFSET_MAX) ? OFFSET_MAX : r_offset + 8'd1;
        n_phase   = r_phase;
        n_etype   = r_etype;
        n_tags    = r_tags;
        n_l3_len  = r_l3_len;
        n_start   = r_start;
        n_pending = r_pending;
        unique case (r_phase)
            PH_ETH: begin
                if (r_offset == ETH_TYPE_HI) begin
                    n_etype = {b, 8'h00};
                end else if (r_offset == ETH_TYPE_LO) begin
                    n_etype = {r_etype[15:8], b};
                    n_phase = f_dispatch(n_etype, n_tags);
                    n_start = n_offset;
                    if (n_phase == PH_DONE) n_pending = {1'b0, RSN_L2};
                end
            end
            PH_VLAN: begin
                if (rel == VLAN_TYPE_HI) begin
                    n_etype = {b, 8'h00};
                end else if (rel == VLAN_TYPE_LO) begin
                    n_etype = {r_etype[15:8], b};
                    n_tags  = r_tags + TAG_W'(1);
                    n_phase = f_dispatch(n_etype, n_tags);
                    n_start = n_offset;
                    if (n_phase == PH_DONE) n_pending = {1'b0, RSN_L2};
                end
            end
            PH_IP4: begin
                if (rel == IP4_VER_IHL) begin
                    n_l3_len = {b[3:0], 2'b00};
                    if (n_l3_len < IP4_MIN_HLEN) begin
                        n_phase   = PH_DONE;
                        n_pending = {1'b0, RSN_IP4};
                    end
                end else if (rel == IP4_PROTO && b != PROTO_ICMP) begin
                    n_phase   = PH_DONE;
                    n_pending = {1'b0, RSN_IP4};
                end
                // header end: on the ihl byte rel is below IP4_MIN_LAST, so this check cannot fire there
                if (n_phase == PH_IP4 && rel >= IP4_MIN_LAST
                        && rel == ({2'b00, r_l3_len} - 8'd1)) begin
                    n_phase = PH_ICMP;
                    n_start = n_offset;
                end
            end
            PH_IP6: begin
                if (rel == IP6_NEXT_HDR && b != NH_ICMP6) begin
                    n_phase   = PH_DONE;
                    n_pending = {1'b0, RSN_IP6};
                end else if (rel == IP6_LAST) begin
                    n_phase = PH_ICMP;
                    n_start = n_offset;
                end
            end
            PH_ICMP: begin
                if (rel == ICMP_TYPE) begin
                    if (b != ((r_etype == ET_IP6) ? ECHO_REQ6 : ECHO_REQ4)) begin
                        n_phase   = PH_DONE;
                        n_pending = {1'b0, RSN_ICMP};
                    end
                end else if (rel == ICMP_SEQ_LO) begin
                    n_phase   = PH_DONE;
                    n_pending = b[0] ? {1'b0, RSN_ODD_SEQ} : {1'b1, RSN_EVEN_ECHO};
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // verdict for a packet ending on this byte
    assign tags_ext = {3'b000, n_tags};
    always_comb begin
        o_verdict.vlan_tags = tags_ext[2:0];
        o_verdict.drop      = 1'b0;
        unique case (n_phase)
            PH_ETH, PH_VLAN: o_verdict.reason = RSN_L2;
            PH_IP4:          o_verdict.reason = RSN_IP4;
            PH_IP6:          o_verdict.reason = RSN_IP6;
            PH_ICMP:         o_verdict.reason = RSN_ICMP;
            default: begin
                o_verdict.drop   = n_pending[3];
                o_verdict.reason = n_pending[2:0];
            end
        endcase
    end

    assign o_push = accept && i_data.last_byte;

    // parser state, restarts after the last byte of each packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_data.last_byte)) begin
            r_offset  <= '0;
            r_phase   <= PH_ETH;
            r_etype   <= '0;
            r_tags    <= '0;
            r_l3_len  <= '0;
            r_start   <= '0;
            r_pending <= {1'b0, RSN_L2};
        end else if (accept) begin
            r_offset  <= n_offset;
            r_phase   <= n_phase;
            r_etype   <= n_etype;
            r_tags    <= n_tags;
            r_l3_len  <= n_l3_len;
            r_start   <= n_start;
            r_pending <= n_pending;
        end
    end

endmodule

@@ hw/rtl/icmpf_queue.sv @@
// icmpf_queue: back end, short verdict queue that drives the output channel
// depends on icmpf_pkg

module icmpf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  icmpf_pkg::t_out_word i_word,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_ready,
    output icmpf_pkg::t_out_word o_word
);
    import icmpf_pkg::*;

    localparam logic [QUEUE_PTR_W:0] DEPTH_CNT = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

    t_out_word              r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   pop;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            if (pop)    r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            case ({i_push, pop})
                2'b10:   r_count <= r_count + (QUEUE_PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_PTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
